### rtl/core/bpsb_pkg.sv
// shared types, constants and helpers of the box plane split bounds block
`timescale 1ns / 1ps

package bpsb_pkg;

  localparam int CW     = 20;  // coordinate width, Q15.4
  localparam int NW     = 16;  // normal width, Q1.14
  localparam int THR_W  = 15;  // skip threshold width
  localparam int KIND_W = 3;
  localparam int QW     = 22;  // quotient bits kept, wider ones saturate
  localparam int D1_W   = 53;  // corner distance width for any frac shift up to 16
  localparam int EXT_W  = CW + 1;
  localparam int MID_W  = QW + 2;
  localparam int VOL_W  = 3 * EXT_W;
  localparam int MET_W  = 61;
  localparam int NORMAL_FRAC_BITS_DEF = 14;

  // divider steps done in each of the three divider stages
  localparam int STEPS_A = 8;
  localparam int STEPS_B = 7;
  localparam int STEPS_C = QW - STEPS_A - STEPS_B;

  localparam logic [KIND_W-1:0] KIND_AX_X = 3'd0;
  localparam logic [KIND_W-1:0] KIND_AX_Y = 3'd1;
  localparam logic [KIND_W-1:0] KIND_AX_Z = 3'd2;

  localparam logic REG_THR_IDX = 1'b0;
  localparam logic [THR_W-1:0] THR_RESET = 15'd1;
  localparam logic [MET_W-1:0] MET_SAT = 61'(1) << 60;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [NW-1:0] norm_t;

  typedef struct packed {
    logic   upd;   // axis not skipped
    logic   pos;   // normal component positive
    coord_t smin;
    coord_t smax;
  } axis_res_t;

  typedef struct packed {
    logic [NW-1:0] r;
    logic [QW-1:0] w;
  } dstep_t;

  typedef struct {
    coord_t           bmin [3];
    coord_t           bmax [3];
    norm_t            n    [3];
    coord_t           pdist;
    logic [KIND_W-1:0] kind;
  } geo_t;

  typedef struct {
    coord_t mn [3];
    coord_t mx [3];
  } box_t;

  // one restoring division step: remainder and dividend/quotient shift word
  function automatic dstep_t div_step(input dstep_t x, input logic [NW-1:0] dv);
    logic [NW:0] t;
    logic        ge;
    dstep_t      res;
    t     = {x.r, x.w[QW-1]};
    ge    = t >= {1'b0, dv};
    res.r = ge ? NW'(t - {1'b0, dv}) : t[NW-1:0];
    res.w = {x.w[QW-2:0], ge};
    return res;
  endfunction

  function automatic logic signed [EXT_W-1:0] extent(input coord_t mn, input coord_t mx);
    return EXT_W'(mx) - EXT_W'(mn);
  endfunction

endpackage

### rtl/core/bpsb_axis_clamp.sv
// per-axis edge intersection, clamp and skip decision for a sloped plane
`timescale 1ns / 1ps

module bpsb_axis_clamp (
  input  bpsb_pkg::coord_t                     bmin_i,
  input  bpsb_pkg::coord_t                     bmax_i,
  input  bpsb_pkg::norm_t                      n_i,
  input  logic [bpsb_pkg::THR_W-1:0]           thr_i,
  input  logic [3:0][bpsb_pkg::QW-1:0]         q_i,
  input  logic [3:0]                           ovf_i,
  input  logic [3:0]                           neg_i,
  output bpsb_pkg::axis_res_t                  res_o
);
  import bpsb_pkg::*;

  always_comb begin
    logic [NW-1:0]           mag;
    logic                    flat;
    logic [QW-1:0]           sq;
    logic signed [MID_W-1:0] val;
    logic signed [MID_W-1:0] mid;
    logic signed [MID_W-1:0] lo;
    logic signed [MID_W-1:0] hi;
    logic signed [MID_W-1:0] smin;
    logic signed [MID_W-1:0] smax;
    mag  = n_i[NW-1] ? NW'(-n_i) : NW'(n_i);
    flat = (n_i == '0) || (bmin_i == bmax_i);
    lo   = MID_W'(bmin_i);
    hi   = MID_W'(bmax_i);
    smin = hi;
    smax = lo;
    for (int e = 0; e < 4; e++) begin
      sq  = ovf_i[e] ? '1 : q_i[e];
      val = $signed({2'b00, sq});
      mid = flat ? lo : (lo + (neg_i[e] ? -val : val));
      smin = (mid < smin) ? mid : smin;
      smin = (smin > lo) ? smin : lo;
      smax = (mid > smax) ? mid : smax;
      smax = (smax < hi) ? smax : hi;
    end
    res_o.upd  = mag >= {1'b0, thr_i};
    res_o.pos  = !n_i[NW-1] && (n_i != '0);
    res_o.smin = CW'(smin);
    res_o.smax = CW'(smax);
  end

endmodule

### rtl/core/box_plane_split_bounds_metric.sv
// top level: box split by a plane into front and back bounds with a volume balance
`timescale 1ns / 1ps

// Each accepted input word carries a box, a plane normal, a distance and a
// plane kind; the block answers with two output words, the front bounds
// (tlast low, metric zero) and then the back bounds (tlast high) with the
// saturated absolute difference of the two box volumes. Axial kinds cut
// their axis at the distance; sloped kinds intersect the plane with the four
// box edges along each axis whose normal magnitude reaches the skip
// threshold register (address 0, reset 1). The work runs through an
// 11-stage pipeline: products, corner distances, divider setup, three
// stages of a restoring divider by the normal component, clamping, and
// four stages of volume multiply and compare. The single output port
// carries two words per item and so bounds the sustained rate; new items
// are taken while earlier ones are still in flight, and a stall on the
// output side fills bubbles first, so inputs keep being taken while
// earlier results wait.
module box_plane_split_bounds_metric #(
  parameter int NORMAL_FRAC_BITS = bpsb_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
  // normal_x, normal_y, normal_z, plane_dist, zero pad
  input  logic [191:0] s_axis_tdata,
  // plane_kind
  input  logic [2:0]   s_axis_tuser,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z,
  // balance_metric, zero pad
  output logic [183:0] m_axis_tdata,
  output logic         m_axis_tlast,   // back_half
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import bpsb_pkg::*;

  localparam int NST = 11;
  localparam int PW  = NW + CW;

  typedef struct {
    geo_t                 g;
    logic signed [PW-1:0] pmin [3];
    logic signed [PW-1:0] pmax [3];
  } st1_t;

  typedef struct {
    geo_t                   g;
    logic signed [D1_W-1:0] d1 [3][4];
  } st2_t;

  typedef struct {
    geo_t          g;
    logic [NW-1:0] dv  [3];
    logic          neg [3][4];
    logic          ovf [3][4];
    logic [NW-1:0] r   [3][4];
    logic [QW-1:0] w   [3][4];
  } div_t;

  typedef struct {
    box_t f;
    box_t b;
  } st7_t;

  typedef struct {
    box_t                      f;
    box_t                      b;
    logic signed [2*EXT_W-1:0] pf;
    logic signed [2*EXT_W-1:0] pb;
    logic signed [EXT_W-1:0]   ezf;
    logic signed [EXT_W-1:0]   ezb;
  } st8_t;

  typedef struct {
    box_t                      f;
    box_t                      b;
    logic signed [2*EXT_W-1:0] hf;
    logic signed [2*EXT_W-1:0] hb;
    logic signed [2*EXT_W:0]   lf;
    logic signed [2*EXT_W:0]   lb;
  } st9_t;

  typedef struct {
    box_t                   f;
    box_t                   b;
    logic signed [VOL_W-1:0] vf;
    logic signed [VOL_W-1:0] vb;
  } st10_t;

  typedef struct {
    box_t             f;
    box_t             b;
    logic [MET_W-1:0] met;
  } st11_t;

  // configuration
  logic [THR_W-1:0] thr_q;
  logic             cfg_wr;

  // pipeline control
  logic [NST-1:0] v_q;
  logic [NST-1:0] rdy;
  logic           half_q;

  st1_t  s1_d,  s1_q;
  st2_t  s2_d,  s2_q;
  div_t  s3_d,  s3_q;
  div_t  s4_d,  s4_q;
  div_t  s5_d,  s5_q;
  div_t  s6_d,  s6_q;
  st7_t  s7_d,  s7_q;
  st8_t  s8_d,  s8_q;
  st9_t  s9_d,  s9_q;
  st10_t s10_d, s10_q;
  st11_t s11_d, s11_q;

  axis_res_t               ares [3];
  logic [3:0][QW-1:0]      aq   [3];
  logic [3:0]              aovf [3];
  logic [3:0]              aneg [3];

  // apb register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_THR_IDX);
  assign prdata = (paddr[2] == REG_THR_IDX) ? {{(32 - THR_W){1'b0}}, thr_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_wr) begin
      thr_q <= pwdata[THR_W-1:0];
    end
  end

  // elastic ready chain, a stage loads when it is empty or its successor moves
  always_comb begin
    rdy[NST-1] = !v_q[NST-1] || (m_axis_tready && half_q);
    for (int k = NST - 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign s_axis_tready = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q    <= '0;
      half_q <= 1'b0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        half_q <= !half_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (rdy[0] && s_axis_tvalid) s1_q  <= s1_d;
    if (rdy[1] && v_q[0])        s2_q  <= s2_d;
    if (rdy[2] && v_q[1])        s3_q  <= s3_d;
    if (rdy[3] && v_q[2])        s4_q  <= s4_d;
    if (rdy[4] && v_q[3])        s5_q  <= s5_d;
    if (rdy[5] && v_q[4])        s6_q  <= s6_d;
    if (rdy[6] && v_q[5])        s7_q  <= s7_d;
    if (rdy[7] && v_q[6])        s8_q  <= s8_d;
    if (rdy[8] && v_q[7])        s9_q  <= s9_d;
    if (rdy[9] && v_q[8])        s10_q <= s10_d;
    if (rdy[10] && v_q[9])       s11_q <= s11_d;
  end

  // stage 1: unpack and normal-by-coordinate products
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      s1_d.g.bmin[a] = s_axis_tdata[a*CW +: CW];
      s1_d.g.bmax[a] = s_axis_tdata[(3 + a)*CW +: CW];
      s1_d.g.n[a]    = s_axis_tdata[6*CW + a*NW +: NW];
    end
    s1_d.g.pdist = s_axis_tdata[6*CW + 3*NW +: CW];
    s1_d.g.kind  = s_axis_tuser;
    for (int a = 0; a < 3; a++) begin
      s1_d.pmin[a] = s1_d.g.n[a] * s1_d.g.bmin[a];
      s1_d.pmax[a] = s1_d.g.n[a] * s1_d.g.bmax[a];
    end
  end

  // stage 2: plane distance of the low end of each edge
  always_comb begin
    logic signed [D1_W-1:0] dsh;
    int bb;
    int cc;
    s2_d.g = s1_q.g;
    dsh    = D1_W'(s1_q.g.pdist) <<< NORMAL_FRAC_BITS;
    for (int a = 0; a < 3; a++) begin
      bb = (a == 2) ? 0 : a + 1;
      cc = (a == 0) ? 2 : a - 1;
      for (int i = 0; i < 2; i++) begin
        for (int j = 0; j < 2; j++) begin
          s2_d.d1[a][i*2+j] = D1_W'(s1_q.pmin[a])
                            + D1_W'((i != 0) ? s1_q.pmax[bb] : s1_q.pmin[bb])
                            + D1_W'((j != 0) ? s1_q.pmax[cc] : s1_q.pmin[cc])
                            - dsh;
        end
      end
    end
  end

  // stage 3: divider setup, magnitudes, quotient sign and overflow
  // the edge extent cancels, so the quotient is d1 over minus the normal
  always_comb begin
    logic [D1_W-1:0]    ad;
    logic [D1_W-QW-1:0] hi;
    logic               npos;
    s3_d.g = s2_q.g;
    for (int a = 0; a < 3; a++) begin
      s3_d.dv[a] = s2_q.g.n[a][NW-1] ? NW'(-s2_q.g.n[a]) : NW'(s2_q.g.n[a]);
      npos       = !s2_q.g.n[a][NW-1] && (s2_q.g.n[a] != '0);
      for (int e = 0; e < 4; e++) begin
        ad = s2_q.d1[a][e][D1_W-1] ? D1_W'(-s2_q.d1[a][e]) : D1_W'(s2_q.d1[a][e]);
        hi = ad[D1_W-1:QW];
        s3_d.ovf[a][e] = hi >= (D1_W - QW)'(s3_d.dv[a]);
        s3_d.neg[a][e] = s2_q.d1[a][e][D1_W-1] ^ npos;
        s3_d.r[a][e]   = hi[NW-1:0];
        s3_d.w[a][e]   = ad[QW-1:0];
      end
    end
  end

  // stages 4 to 6: restoring division, a few quotient bits per stage
  always_comb begin
    dstep_t t;
    s4_d = s3_q;
    for (int a = 0; a < 3; a++) begin
      for (int e = 0; e < 4; e++) begin
        t.r = s3_q.r[a][e];
        t.w = s3_q.w[a][e];
        for (int s = 0; s < STEPS_A; s++) t = div_step(t, s3_q.dv[a]);
        s4_d.r[a][e] = t.r;
        s4_d.w[a][e] = t.w;
      end
    end
  end

  always_comb begin
    dstep_t t;
    s5_d = s4_q;
    for (int a = 0; a < 3; a++) begin
      for (int e = 0; e < 4; e++) begin
        t.r = s4_q.r[a][e];
        t.w = s4_q.w[a][e];
        for (int s = 0; s < STEPS_B; s++) t = div_step(t, s4_q.dv[a]);
        s5_d.r[a][e] = t.r;
        s5_d.w[a][e] = t.w;
      end
    end
  end

  always_comb begin
    dstep_t t;
    s6_d = s5_q;
    for (int a = 0; a < 3; a++) begin
      for (int e = 0; e < 4; e++) begin
        t.r = s5_q.r[a][e];
        t.w = s5_q.w[a][e];
        for (int s = 0; s < STEPS_C; s++) t = div_step(t, s5_q.dv[a]);
        s6_d.r[a][e] = t.r;
        s6_d.w[a][e] = t.w;
      end
    end
  end

  // stage 7: intersections, clamps and front/back assignment
  for (genvar a = 0; a < 3; a++) begin : g_axis
    for (genvar e = 0; e < 4; e++) begin : g_edge
      assign aq[a][e]   = s6_q.w[a][e];
      assign aovf[a][e] = s6_q.ovf[a][e];
      assign aneg[a][e] = s6_q.neg[a][e];
    end

    bpsb_axis_clamp u_clamp (
      .bmin_i (s6_q.g.bmin[a]),
      .bmax_i (s6_q.g.bmax[a]),
      .n_i    (s6_q.g.n[a]),
      .thr_i  (thr_q),
      .q_i    (aq[a]),
      .ovf_i  (aovf[a]),
      .neg_i  (aneg[a]),
      .res_o  (ares[a])
    );
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      s7_d.f.mn[a] = s6_q.g.bmin[a];
      s7_d.f.mx[a] = s6_q.g.bmax[a];
      s7_d.b.mn[a] = s6_q.g.bmin[a];
      s7_d.b.mx[a] = s6_q.g.bmax[a];
    end
    unique case (s6_q.g.kind)
      KIND_AX_X: begin
        s7_d.f.mn[0] = s6_q.g.pdist;
        s7_d.b.mx[0] = s6_q.g.pdist;
      end
      KIND_AX_Y: begin
        s7_d.f.mn[1] = s6_q.g.pdist;
        s7_d.b.mx[1] = s6_q.g.pdist;
      end
      KIND_AX_Z: begin
        s7_d.f.mn[2] = s6_q.g.pdist;
        s7_d.b.mx[2] = s6_q.g.pdist;
      end
      default: begin
        // sloped plane, unknown kinds included
        for (int a = 0; a < 3; a++) begin
          if (ares[a].upd) begin
            if (ares[a].pos) begin
              s7_d.f.mn[a] = ares[a].smin;
              s7_d.b.mx[a] = ares[a].smax;
            end else begin
              s7_d.b.mn[a] = ares[a].smin;
              s7_d.f.mx[a] = ares[a].smax;
            end
          end
        end
      end
    endcase
  end

  // stage 8: extents and x by y area
  always_comb begin
    s8_d.f   = s7_q.f;
    s8_d.b   = s7_q.b;
    s8_d.pf  = extent(s7_q.f.mn[0], s7_q.f.mx[0]) * extent(s7_q.f.mn[1], s7_q.f.mx[1]);
    s8_d.pb  = extent(s7_q.b.mn[0], s7_q.b.mx[0]) * extent(s7_q.b.mn[1], s7_q.b.mx[1]);
    s8_d.ezf = extent(s7_q.f.mn[2], s7_q.f.mx[2]);
    s8_d.ezb = extent(s7_q.b.mn[2], s7_q.b.mx[2]);
  end

  // stage 9: area times z, split in high and low partial products
  always_comb begin
    s9_d.f  = s8_q.f;
    s9_d.b  = s8_q.b;
    s9_d.hf = $signed(s8_q.pf[2*EXT_W-1:EXT_W]) * s8_q.ezf;
    s9_d.hb = $signed(s8_q.pb[2*EXT_W-1:EXT_W]) * s8_q.ezb;
    s9_d.lf = $signed({1'b0, s8_q.pf[EXT_W-1:0]}) * s8_q.ezf;
    s9_d.lb = $signed({1'b0, s8_q.pb[EXT_W-1:0]}) * s8_q.ezb;
  end

  // stage 10: recombine volumes
  always_comb begin
    s10_d.f  = s9_q.f;
    s10_d.b  = s9_q.b;
    s10_d.vf = (VOL_W'(s9_q.hf) <<< EXT_W) + VOL_W'(s9_q.lf);
    s10_d.vb = (VOL_W'(s9_q.hb) <<< EXT_W) + VOL_W'(s9_q.lb);
  end

  // stage 11: absolute difference with saturation
  always_comb begin
    logic signed [VOL_W:0] diff;
    logic        [VOL_W:0] ad;
    s11_d.f = s10_q.f;
    s11_d.b = s10_q.b;
    diff    = (VOL_W + 1)'(s10_q.vf) - (VOL_W + 1)'(s10_q.vb);
    ad      = diff[VOL_W] ? (VOL_W + 1)'(-diff) : (VOL_W + 1)'(diff);
    s11_d.met = (ad > (VOL_W + 1)'(MET_SAT)) ? MET_SAT : ad[MET_W-1:0];
  end

  // output: front word then back word from the last stage
  always_comb begin
    box_t bx;
    bx = half_q ? s11_q.b : s11_q.f;
    m_axis_tdata = {3'b000, half_q ? s11_q.met : {MET_W{1'b0}},
                    bx.mx[2], bx.mx[1], bx.mx[0], bx.mn[2], bx.mn[1], bx.mn[0]};
  end

  assign m_axis_tvalid = v_q[NST-1];
  assign m_axis_tlast  = half_q;

  // a front word is always followed by its back word
  a_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid && m_axis_tlast)
    else $error("front word not followed by back word");

  // the last stage keeps its item until the back word is taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[NST-1] && !(m_axis_tready && half_q) |=> v_q[NST-1])
    else $error("result dropped before delivery");

  // an accepted word lands in the first stage
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> v_q[0])
    else $error("accepted word lost at entry");

  // an empty first stage never blocks the input
  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_q[0] |-> s_axis_tready)
    else $error("input stalled with empty entry stage");

endmodule

### bench/tb_box_plane_split_bounds_metric.sv
// testbench for the box plane split bounds block: scoreboard class, stream and apb drivers
`timescale 1ns / 1ps

// one output word as the block should produce it
typedef struct {
  logic         back;
  logic [183:0] data;
} split_word_t;

// computes the front and back bounds of each accepted box and checks the outputs
class split_bounds_board;
  split_word_t pending[$];
  logic [14:0] skip_thr;
  int          n_err;
  int          n_words;

  function new();
    skip_thr = 15'd1;
    n_err    = 0;
    n_words  = 0;
  endfunction

  function automatic longint signed dist_of(longint signed n[3], longint signed c[3],
                                            longint signed d);
    return n[0] * c[0] + n[1] * c[1] + n[2] * c[2] - d * 64'sd16384;
  endfunction

  function automatic longint signed vol(longint signed mn[3], longint signed mx[3]);
    return (mx[0] - mn[0]) * (mx[1] - mn[1]) * (mx[2] - mn[2]);
  endfunction

  function automatic logic [183:0] pack_box(longint signed mn[3], longint signed mx[3],
                                            logic [60:0] met);
    logic [183:0] w;
    w = '0;
    for (int k = 0; k < 3; k++) begin
      w[k*20 +: 20]     = mn[k][19:0];
      w[60 + k*20 +: 20] = mx[k][19:0];
    end
    w[120 +: 61] = met;
    return w;
  endfunction

  // note an accepted input word and queue its two results
  function void note_box(logic [191:0] d, logic [2:0] kind);
    longint signed bmin[3], bmax[3], n[3], fmin[3], fmax[3], kmin[3], kmax[3];
    longint signed pd, cr[3], d1, d2, den, mid, smin, smax, diff;
    longint unsigned mag;
    int b, c;
    split_word_t w;
    for (int a = 0; a < 3; a++) begin
      bmin[a] = longint'($signed(d[a*20 +: 20]));
      bmax[a] = longint'($signed(d[60 + a*20 +: 20]));
      n[a]    = longint'($signed(d[120 + a*16 +: 16]));
      fmin[a] = bmin[a]; kmin[a] = bmin[a];
      fmax[a] = bmax[a]; kmax[a] = bmax[a];
    end
    pd = longint'($signed(d[168 +: 20]));
    if (kind < 3) begin
      fmin[kind] = pd;
      kmax[kind] = pd;
    end else begin
      for (int a = 0; a < 3; a++) begin
        b = (a + 1) % 3;
        c = (a + 2) % 3;
        smin = bmax[a];
        smax = bmin[a];
        mag = (n[a] < 0) ? -n[a] : n[a];
        if (mag < skip_thr) continue;
        for (int i = 0; i < 2; i++) begin
          for (int j = 0; j < 2; j++) begin
            cr[b] = i ? bmax[b] : bmin[b];
            cr[c] = j ? bmax[c] : bmin[c];
            cr[a] = bmin[a];
            d1 = dist_of(n, cr, pd);
            cr[a] = bmax[a];
            d2 = dist_of(n, cr, pd);
            den = d1 - d2;
            mid = (den == 0) ? bmin[a] : bmin[a] + ((bmax[a] - bmin[a]) * d1) / den;
            smin = (mid < smin) ? mid : smin;
            smin = (smin > bmin[a]) ? smin : bmin[a];
            smax = (mid > smax) ? mid : smax;
            smax = (smax < bmax[a]) ? smax : bmax[a];
          end
        end
        if (n[a] > 0) begin
          fmin[a] = smin; kmax[a] = smax;
        end else begin
          kmin[a] = smin; fmax[a] = smax;
        end
      end
    end
    diff = vol(fmin, fmax) - vol(kmin, kmax);
    if (diff < 0) diff = -diff;
    w.back = 1'b0;
    w.data = pack_box(fmin, fmax, '0);
    pending = {pending, w};
    w.back = 1'b1;
    w.data = pack_box(kmin, kmax,
                      (longint'(diff) > (64'sd1 <<< 60)) ? 61'(1) << 60 : diff[60:0]);
    pending = {pending, w};
  endfunction

  // compare one output word against the oldest expectation
  function void check_word(logic [183:0] d, logic last);
    split_word_t e;
    string nm[7] = '{"out_min_x", "out_min_y", "out_min_z",
                     "out_max_x", "out_max_y", "out_max_z", "balance_metric"};
    n_words++;
    if (pending.size() == 0) begin
      $error("unexpected output word %h", d);
      n_err++;
      return;
    end
    e = pending.pop_front();
    if (e.back !== last) begin
      $error("back_half expected %0d got %0d", e.back, last);
      n_err++;
    end
    for (int k = 0; k < 6; k++)
      if (e.data[k*20 +: 20] !== d[k*20 +: 20]) begin
        $error("%s expected %0d got %0d", nm[k], $signed(e.data[k*20 +: 20]),
               $signed(d[k*20 +: 20]));
        n_err++;
      end
    if (e.data[183:120] !== d[183:120]) begin
      $error("%s expected %0d got %0d", nm[6], e.data[183:120], d[183:120]);
      n_err++;
    end
  endfunction
endclass

module tb_box_plane_split_bounds_metric;
  localparam int WDOG_LIMIT = 2000;
  localparam int LATENCY    = 16;
  localparam int N_RANDOM   = 1830;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic [191:0] s_axis_tdata = '0;
  logic [2:0]   s_axis_tuser = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [183:0] m_axis_tdata;
  logic         m_axis_tlast;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  split_bounds_board board = new();
  int  idle_cycles = 0;
  int  n_boxes = 0;
  bit  timed_out = 1'b0;

  always #10 clk_i = ~clk_i;

  box_plane_split_bounds_metric uut (.*);

  // watchdog: cycles with no word moving on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WDOG_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("box_plane_split_bounds_metric test failed");
      $finish;
    end
  end

  // output side: check every accepted word, random stall before each
  initial begin : sink
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      board.check_word(m_axis_tdata, m_axis_tlast);
    end
  end

  task automatic apb_write(input logic [14:0] thr);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= '0; pwdata <= 32'(thr);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    board.skip_thr = thr;
  endtask

  // send one box, with a random gap before it unless asked for none
  task automatic send_box(input logic [191:0] d, input logic [2:0] kind, input bit burst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= d;
    s_axis_tuser  <= kind;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_box(d, kind);
    n_boxes++;
  endtask

  function automatic logic [191:0] make_box(int mn[3], int mx[3], int nv[3], int pd);
    logic [191:0] d;
    d = '0;
    for (int k = 0; k < 3; k++) begin
      d[k*20 +: 20]      = mn[k][19:0];
      d[60 + k*20 +: 20]  = mx[k][19:0];
      d[120 + k*16 +: 16] = nv[k][15:0];
    end
    d[168 +: 20] = pd[19:0];
    return d;
  endfunction

  // random item: mostly well-formed boxes and unit-ish normals, some raw noise
  function automatic logic [191:0] rand_box();
    int mn[3], mx[3], nv[3], span, t, pd;
    logic [191:0] d;
    if ($urandom_range(0, 9) == 0) begin
      d = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      d[191:188] = '0;
      return d;
    end
    span = ($urandom_range(0, 3) == 0) ? 524287 : 4096;
    for (int k = 0; k < 3; k++) begin
      mn[k] = $urandom_range(0, 2 * span) - span;
      mx[k] = $urandom_range(0, 2 * span) - span;
      if (mn[k] > mx[k] && $urandom_range(0, 7) != 0) begin
        t = mn[k]; mn[k] = mx[k]; mx[k] = t;
      end
      if ($urandom_range(0, 15) == 0) mx[k] = mn[k];
      case ($urandom_range(0, 5))
        0:       nv[k] = 0;
        1:       nv[k] = ($urandom_range(0, 1)) ? 16384 : -16384;
        2:       nv[k] = $urandom_range(0, 65535) - 32768;
        default: nv[k] = $urandom_range(0, 32768) - 16384;
      endcase
    end
    pd = (mn[0] + mx[0]) / 2 + $urandom_range(0, 2 * span) - span;
    if (pd > 524287) pd = 524287;
    if (pd < -524288) pd = -524288;
    return make_box(mn, mx, nv, pd);
  endfunction

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  initial begin : source
    int lo[3] = '{-524288, -524288, -524288};
    int hi[3] = '{524287, 524287, 524287};
    int sm[3] = '{-160, -32, 0};
    int sx[3] = '{160, 320, 64};
    int nv[3];
    logic [14:0] thr_set[4] = '{15'd0, 15'd16384, 15'd8000, 15'd1};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every kind including the unknown ones
    for (int k = 0; k < 8; k++) begin
      nv = '{9000, -7000, 11000};
      send_box(make_box(sm, sx, nv, 20), 3'(k), 1'b0);
    end
    // full-range box, extreme normals and distance
    nv = '{16384, -16384, 16384};
    send_box(make_box(lo, hi, nv, 524287), 3'd3, 1'b0);
    nv = '{-32768, 32767, -16384};
    send_box(make_box(lo, hi, nv, -524288), 3'd4, 1'b0);
    send_box(make_box(hi, lo, nv, 0), 3'd5, 1'b0);   // inverted box
    send_box(make_box(lo, hi, nv, -524288), 3'd0, 1'b0);
    // flat box gives a zero divisor
    nv = '{5000, 5000, 5000};
    send_box(make_box(sm, sm, nv, 3), 3'd3, 1'b0);
    // zero normal with threshold zero
    drain();
    apb_write(15'd0);
    nv = '{0, 0, 4000};
    send_box(make_box(sm, sx, nv, 1), 3'd5, 1'b0);
    nv = '{0, -3, 0};
    send_box(make_box(sm, sx, nv, 1), 3'd4, 1'b0);

    // random phases over several thresholds
    for (int p = 0; p < 4; p++) begin
      drain();
      apb_write(thr_set[p]);
      for (int i = 0; i < N_RANDOM / 4; i++) begin
        if (i == 100) drain();   // sender waits for every result
        send_box(rand_box(), 3'($urandom_range(0, 7)), ($urandom_range(0, 3) == 0));
      end
    end

    drain();
    $display("sent %0d boxes under several skip thresholds, checked %0d output words",
             n_boxes, board.n_words);
    if (board.n_err == 0)
      $display("box_plane_split_bounds_metric test passed");
    else
      $display("box_plane_split_bounds_metric test failed");
    $finish;
  end
endmodule

### box_plane_split_bounds_metric.f
rtl/core/bpsb_pkg.sv
rtl/core/bpsb_axis_clamp.sv
rtl/core/box_plane_split_bounds_metric.sv
bench/tb_box_plane_split_bounds_metric.sv
